@@ hw/rtl/zph_pkg.sv @@
// shared types and constants of the zobrist position hash core
`default_nettype none

package zph_pkg;

   localparam int BOARD_SQUARES = 64;
   localparam int PIECE_KINDS   = 7;
   localparam int COLORS        = 2;
   localparam int KEY_COUNT     = COLORS * PIECE_KINDS * BOARD_SQUARES + 1 + 16 + 8;
   localparam int KEY_ADDR_W    = $clog2(KEY_COUNT);

   localparam logic [KEY_ADDR_W-1:0] SIDE_AT   = KEY_ADDR_W'(COLORS * PIECE_KINDS * BOARD_SQUARES);
   localparam logic [KEY_ADDR_W-1:0] CASTLE_AT = KEY_ADDR_W'(COLORS * PIECE_KINDS * BOARD_SQUARES + 1);
   localparam logic [KEY_ADDR_W-1:0] EP_AT     = KEY_ADDR_W'(COLORS * PIECE_KINDS * BOARD_SQUARES + 17);
   localparam logic [KEY_ADDR_W-1:0] LAST_KEY  = KEY_ADDR_W'(KEY_COUNT - 1);

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
   localparam logic [63:0] SEED_RESET   = 64'h0C0F_FEE1_2345_6789;

   localparam logic [1:0] ACTION_REGEN  = 2'd0;
   localparam logic [1:0] ACTION_TOGGLE = 2'd1;
   localparam logic [1:0] ACTION_FINISH = 2'd2;

   localparam logic [2:0] PIECE_EMPTY   = 3'd0;
   localparam logic [2:0] PIECE_INVALID = 3'd7;

   // register select is byte address bit 3
   localparam logic CSR_KEY_SEED = 1'b0;

   typedef enum logic [1:0] {
      CMD_REGEN,
      CMD_TOGGLE,
      CMD_FINISH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [KEY_ADDR_W-1:0] addr_a;
      logic [KEY_ADDR_W-1:0] addr_b;
      logic                  black;
      logic                  ep_valid;
   } cmd_type;

   typedef struct packed {
      logic                  en;
      logic [KEY_ADDR_W-1:0] addr;
      logic [63:0]           data;
   } key_write_type;

endpackage

`default_nettype wire

@@ hw/rtl/zph_front.sv @@
// front end: takes request words and turns them into queued commands
`default_nettype none

module zph_front import zph_pkg::*; (
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [1:0]        req_action,
   input  wire logic              req_piece_color,
   input  wire logic [2:0]        req_piece_type,
   input  wire logic [5:0]        req_square,
   input  wire logic              req_black_to_move,
   input  wire logic [3:0]        req_castling_rights,
   input  wire logic signed [3:0] req_en_passant_column,
   input  wire logic              queue_full,
   output      logic              push,
   output      cmd_type           push_cmd
);

   logic       keep;
   logic [3:0] piece_row;

   assign piece_row = req_piece_color ? 4'(PIECE_KINDS) + {1'b0, req_piece_type}
                                      : {1'b0, req_piece_type};

   always_comb begin
      keep              = 1'b0;
      push_cmd.kind     = CMD_TOGGLE;
      push_cmd.addr_a   = {piece_row, req_square};
      push_cmd.addr_b   = EP_AT + KEY_ADDR_W'(req_en_passant_column[2:0]);
      push_cmd.black    = req_black_to_move;
      push_cmd.ep_valid = ~req_en_passant_column[3];
      unique case (req_action)
         ACTION_REGEN: begin
            push_cmd.kind = CMD_REGEN;
            keep          = 1'b1;
         end
         ACTION_TOGGLE: begin
            push_cmd.kind = CMD_TOGGLE;
            keep          = (req_piece_type != PIECE_EMPTY) && (req_piece_type != PIECE_INVALID);
         end
         ACTION_FINISH: begin
            push_cmd.kind   = CMD_FINISH;
            push_cmd.addr_a = CASTLE_AT + KEY_ADDR_W'(req_castling_rights);
            keep            = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full & keep;

endmodule

`default_nettype wire

@@ hw/rtl/zph_queue.sv @@
// short command queue between front and back end
`default_nettype none

module zph_queue import zph_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output      logic    full,
   output      logic    head_valid,
   output      cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/zph_keygen.sv @@
// splitmix64 key generator on one shared 32x32 multiplier
`default_nettype none

module zph_keygen import zph_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [63:0]   seed,
   output      key_write_type key_write,
   output      logic          done
);

   typedef enum logic [2:0] {
      G_IDLE,
      G_ADVANCE,
      G_MUL,
      G_MIX,
      G_EMIT
   } gen_state_type;

   gen_state_type         state_ff;
   logic [63:0]           x_ff;
   logic [63:0]           z_ff;
   logic [63:0]           prod_ff;
   logic [1:0]            mstep_ff;
   logic                  pass_ff;
   logic [KEY_ADDR_W-1:0] idx_ff;

   logic [63:0] x_in;
   logic [63:0] mul_const;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_full;
   logic        last_key;

   assign x_in      = x_ff + GOLDEN_GAMMA;
   assign mul_const = pass_ff ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a     = (mstep_ff == 2'd2) ? z_ff[63:32] : z_ff[31:0];
   assign mul_b     = (mstep_ff == 2'd1) ? mul_const[63:32] : mul_const[31:0];
   assign mul_full  = mul_a * mul_b;
   assign last_key  = (idx_ff == LAST_KEY);

   assign key_write.en   = (state_ff == G_EMIT);
   assign key_write.addr = idx_ff;
   assign key_write.data = prod_ff ^ (prod_ff >> 31);
   assign done           = (state_ff == G_EMIT) && last_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         mstep_ff <= '0;
         pass_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            G_IDLE: begin
               if (start) begin
                  x_ff     <= seed;
                  idx_ff   <= '0;
                  state_ff <= G_ADVANCE;
               end
            end
            G_ADVANCE: begin
               x_ff     <= x_in;
               z_ff     <= x_in ^ (x_in >> 30);
               mstep_ff <= '0;
               pass_ff  <= 1'b0;
               state_ff <= G_MUL;
            end
            G_MUL: begin
               // low half product first, then the two cross terms
               if (mstep_ff == 2'd0) begin
                  prod_ff <= mul_full;
               end else begin
                  prod_ff <= prod_ff + {mul_full[31:0], 32'b0};
               end
               if (mstep_ff == 2'd2) begin
                  mstep_ff <= '0;
                  state_ff <= pass_ff ? G_EMIT : G_MIX;
               end else begin
                  mstep_ff <= mstep_ff + 1'b1;
               end
            end
            G_MIX: begin
               z_ff     <= prod_ff ^ (prod_ff >> 27);
               pass_ff  <= 1'b1;
               state_ff <= G_MUL;
            end
            G_EMIT: begin
               if (last_key) begin
                  state_ff <= G_IDLE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= G_ADVANCE;
               end
            end
            default: begin
               state_ff <= G_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/zph_back.sv @@
// back end: key store, hash accumulator and result word register
`default_nettype none

module zph_back import zph_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire cmd_type       head_cmd,
   output      logic          pop,
   output      logic          gen_start,
   input  wire key_write_type key_write,
   input  wire logic          gen_done,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      logic [63:0]   rsp_position_hash
);

   typedef enum logic [2:0] {
      S_RUN,
      S_REGEN,
      S_FIN_CASTLE,
      S_FIN_EP,
      S_FIN_EMIT
   } back_state_type;

   back_state_type        state_ff;
   cmd_type               fin_ff;
   logic                  tog_pend_ff;
   logic [63:0]           acc_ff;
   logic [63:0]           fold_ff;
   logic                  rsp_valid_ff;
   logic [63:0]           rsp_hash_ff;
   logic [63:0]           rd_data_ff;
   logic [63:0]           key_mem [KEY_COUNT];

   logic [KEY_ADDR_W-1:0] rd_addr;
   logic                  out_free;
   logic                  emit;

   assign out_free          = ~rsp_valid_ff | ~rsp_stall;
   assign emit              = (state_ff == S_FIN_EMIT) && out_free;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position_hash = rsp_hash_ff;

   always_comb begin
      pop       = 1'b0;
      gen_start = 1'b0;
      rd_addr   = fin_ff.addr_b;
      unique case (state_ff)
         S_RUN: begin
            pop = head_valid;
            unique case (head_cmd.kind)
               CMD_TOGGLE: rd_addr   = head_cmd.addr_a;
               CMD_FINISH: rd_addr   = SIDE_AT;
               CMD_REGEN:  gen_start = head_valid;
               default:    rd_addr   = head_cmd.addr_a;
            endcase
         end
         S_FIN_CASTLE: rd_addr = fin_ff.addr_a;
         default:      rd_addr = fin_ff.addr_b;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_write.en) begin
         key_mem[key_write.addr] <= key_write.data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         tog_pend_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tog_pend_ff <= (state_ff == S_RUN) && head_valid && (head_cmd.kind == CMD_TOGGLE);
         if (tog_pend_ff) begin
            acc_ff <= acc_ff ^ rd_data_ff;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_RUN: begin
               if (head_valid) begin
                  unique case (head_cmd.kind)
                     CMD_TOGGLE: state_ff <= S_RUN;
                     CMD_REGEN:  state_ff <= S_REGEN;
                     CMD_FINISH: begin
                        fin_ff   <= head_cmd;
                        state_ff <= S_FIN_CASTLE;
                     end
                     default: state_ff <= S_RUN;
                  endcase
               end
            end
            S_REGEN: begin
               if (gen_done) begin
                  state_ff <= S_RUN;
               end
            end
            S_FIN_CASTLE: begin
               // side key arrives here
               fold_ff  <= fin_ff.black ? rd_data_ff : '0;
               state_ff <= S_FIN_EP;
            end
            S_FIN_EP: begin
               fold_ff  <= fold_ff ^ rd_data_ff;
               state_ff <= S_FIN_EMIT;
            end
            S_FIN_EMIT: begin
               if (out_free) begin
                  rsp_hash_ff  <= acc_ff ^ fold_ff ^ (fin_ff.ep_valid ? rd_data_ff : '0);
                  acc_ff       <= '0;
                  state_ff     <= S_RUN;
               end
            end
            default: begin
               state_ff <= S_RUN;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/zobrist_position_hash_core.sv @@
// top level of the zobrist position hash core
//
//   port group | direction | handshake           | contents
//   req_       | in        | req_valid/req_stall | action and position fields
//   rsp_       | out       | rsp_valid/rsp_stall | 64-bit position hash
//   csr_       | in/out    | apb psel/penable    | key_seed at byte address 0
//
// toggles retire one per cycle via the single key store read port unless the back end is busy
// finish runs in the back end as three key store reads (side, castle, en passant) and the emit
// regenerate writes 921 keys, each computed on the shared 32x32 multiplier
// reset empties queue and accumulator and reloads the seed reset value
// key store holds garbage until first regenerate
// req_stall rises when the command queue is full; rsp_stall holds the emit step
`default_nettype none

module zobrist_position_hash_core import zph_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [1:0]        req_action,
   input  wire logic              req_piece_color,
   input  wire logic [2:0]        req_piece_type,
   input  wire logic [5:0]        req_square,
   input  wire logic              req_black_to_move,
   input  wire logic [3:0]        req_castling_rights,
   input  wire logic signed [3:0] req_en_passant_column,

   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [63:0]       rsp_position_hash,

   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [3:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output      logic [63:0]       csr_prdata,
   output      logic              csr_pready
);

   logic          queue_full;
   logic          push;
   cmd_type       push_cmd;
   logic          pop;
   logic          head_valid;
   cmd_type       head_cmd;
   logic          gen_start;
   logic          gen_done;
   key_write_type key_write;
   logic [63:0]   key_seed_ff;
   logic          seed_sel;

   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[3] == CSR_KEY_SEED);
   assign csr_prdata = seed_sel ? key_seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seed_ff <= SEED_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && seed_sel) begin
         key_seed_ff <= csr_pwdata;
      end
   end

   zph_front u_front (
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_piece_color       (req_piece_color),
      .req_piece_type        (req_piece_type),
      .req_square            (req_square),
      .req_black_to_move     (req_black_to_move),
      .req_castling_rights   (req_castling_rights),
      .req_en_passant_column (req_en_passant_column),
      .queue_full            (queue_full),
      .push                  (push),
      .push_cmd              (push_cmd)
   );

   zph_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   zph_keygen u_keygen (
      .clock     (clock),
      .reset     (reset),
      .start     (gen_start),
      .seed      (key_seed_ff),
      .key_write (key_write),
      .done      (gen_done)
   );

   zph_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .gen_start         (gen_start),
      .key_write         (key_write),
      .gen_done          (gen_done),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position_hash (rsp_position_hash)
   );

endmodule

`default_nettype wire

@@ verif/tb_zobrist_position_hash_core.sv @@
// testbench of the zobrist position hash core: in-order hash prediction checked on every response
`default_nettype none

module tb_zobrist_position_hash_core import zph_pkg::*;;

   localparam int          SQUARES        = 64;
   localparam int          KINDS          = 7;
   localparam int          SIDE_KEY       = 2 * KINDS * SQUARES;
   localparam int          CASTLE_KEY     = SIDE_KEY + 1;
   localparam int          EP_KEY         = CASTLE_KEY + 16;
   localparam int          NUM_KEYS       = EP_KEY + 8;
   localparam logic [63:0] GAMMA          = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_A          = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MUL_B          = 64'h94d049bb133111eb;
   localparam logic [63:0] SEED_AT_RESET  = 64'h0c0ffee123456789;
   localparam logic [1:0]  ACTION_NOP     = 2'd3;
   localparam logic [3:0]  ADDR_KEY_SEED  = 4'h0;
   localparam int          STALL_PCT      = 16;
   localparam int          WATCHDOG_LIMIT = 200000;
   localparam int          RANDOM_WORDS   = 1250;
   localparam int          RANDOM_PHASES  = 5;

   typedef struct packed {
      logic [1:0]        action;
      logic              piece_color;
      logic [2:0]        piece_type;
      logic [5:0]        square;
      logic              black_to_move;
      logic [3:0]        castling_rights;
      logic signed [3:0] en_passant_column;
   } pos_word_type;

   logic              clock;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action = '0;
   logic              req_piece_color = 1'b0;
   logic [2:0]        req_piece_type = '0;
   logic [5:0]        req_square = '0;
   logic              req_black_to_move = 1'b0;
   logic [3:0]        req_castling_rights = '0;
   logic signed [3:0] req_en_passant_column = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [63:0]       rsp_position_hash;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [3:0]        csr_paddr = '0;
   logic [63:0]       csr_pwdata = '0;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   pos_word_type      word_q[$];
   logic [63:0]       hash_q[$];
   pos_word_type      cur_word;
   logic [63:0]       want_hash;

   logic [63:0]       key_bank [NUM_KEYS];
   logic [63:0]       running_hash = '0;
   logic [63:0]       seed_copy = SEED_AT_RESET;

   bit                quiet = 1'b0;
   int                error_count = 0;
   int                words_queued = 0;
   int                words_sent = 0;
   int                hashes_checked = 0;
   int                regen_count = 0;
   int                seeds_used = 0;
   int                dead_cycles = 0;

   zobrist_position_hash_core uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_piece_color       (req_piece_color),
      .req_piece_type        (req_piece_type),
      .req_square            (req_square),
      .req_black_to_move     (req_black_to_move),
      .req_castling_rights   (req_castling_rights),
      .req_en_passant_column (req_en_passant_column),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_position_hash     (rsp_position_hash),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void predict_word(input pos_word_type w);
      logic [63:0] gen;
      logic [63:0] z;
      logic [63:0] h;
      int          i;
      case (w.action)
         ACTION_REGEN: begin
            gen = seed_copy;
            for (i = 0; i < NUM_KEYS; i++) begin
               gen = gen + GAMMA;
               z = (gen ^ (gen >> 30)) * MUL_A;
               z = (z ^ (z >> 27)) * MUL_B;
               key_bank[i] = z ^ (z >> 31);
            end
         end
         ACTION_TOGGLE: begin
            if (w.piece_type != PIECE_EMPTY && w.piece_type != PIECE_INVALID)
               running_hash ^= key_bank[(int'(w.piece_color) * KINDS + int'(w.piece_type))
                                        * SQUARES + int'(w.square)];
         end
         ACTION_FINISH: begin
            h = running_hash;
            if (w.black_to_move)
               h ^= key_bank[SIDE_KEY];
            h ^= key_bank[CASTLE_KEY + int'(w.castling_rights)];
            if (!w.en_passant_column[3])
               h ^= key_bank[EP_KEY + int'(w.en_passant_column[2:0])];
            hash_q.push_back(h);
            running_hash = '0;
         end
         default: ;
      endcase
   endfunction

   // request driver: updates the prediction on each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_word(cur_word);
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (word_q.size() != 0 && (quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
               cur_word = word_q.pop_front();
               req_valid             <= 1'b1;
               req_action            <= cur_word.action;
               req_piece_color       <= cur_word.piece_color;
               req_piece_type        <= cur_word.piece_type;
               req_square            <= cur_word.square;
               req_black_to_move     <= cur_word.black_to_move;
               req_castling_rights   <= cur_word.castling_rights;
               req_en_passant_column <= cur_word.en_passant_column;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hash_q.size() == 0) begin
               $error("position_hash: no word expected, got 0x%016h", rsp_position_hash);
               error_count++;
            end else begin
               want_hash = hash_q.pop_front();
               if (rsp_position_hash !== want_hash) begin
                  $error("position_hash: expected 0x%016h, got 0x%016h",
                         want_hash, rsp_position_hash);
                  error_count++;
               end
               hashes_checked++;
            end
         end
         rsp_stall <= !quiet && $urandom_range(0, 99) < STALL_PCT;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dead_cycles <= 0;
      end else if (dead_cycles >= WATCHDOG_LIMIT) begin
         $display("zobrist_position_hash_core verification failed");
         $finish;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
   end

   function automatic pos_word_type any_word(input logic [1:0] action);
      pos_word_type w;
      logic [31:0]  r;
      r = $urandom;
      w = r[$bits(pos_word_type)-1:0];
      w.action = action;
      return w;
   endfunction

   task automatic send_word(input pos_word_type w);
      while (word_q.size() >= 2)
         @(negedge clock);
      word_q.push_back(w);
      words_queued++;
   endtask

   task automatic send_toggle(input logic c, input logic [2:0] t, input logic [5:0] s);
      pos_word_type w;
      w = any_word(ACTION_TOGGLE);
      w.piece_color = c;
      w.piece_type  = t;
      w.square      = s;
      send_word(w);
   endtask

   task automatic send_finish(input logic b, input logic [3:0] cr, input logic [3:0] ep);
      pos_word_type w;
      w = any_word(ACTION_FINISH);
      w.black_to_move     = b;
      w.castling_rights   = cr;
      w.en_passant_column = ep;
      send_word(w);
   endtask

   task automatic send_regen();
      send_word(any_word(ACTION_REGEN));
      regen_count++;
   endtask

   task automatic wait_idle();
      while (word_q.size() != 0 || req_valid || hash_q.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_seed(input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_KEY_SEED;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      seed_copy = value;
      seeds_used++;
   endtask

   task automatic check_seed_readback();
      logic [63:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_KEY_SEED;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== seed_copy) begin
         $error("key_seed: expected 0x%016h, got 0x%016h", seed_copy, got);
         error_count++;
      end
   endtask

   // a run of toggles closed by a finish, with odd words mixed in at wild_pct
   task automatic play_game(input int moves, input int wild_pct);
      int i;
      for (i = 0; i < moves; i++) begin
         if ($urandom_range(0, 99) < wild_pct) begin
            case ($urandom_range(0, 5))
               0, 1: send_toggle(1'($urandom), $urandom_range(0, 1) ? PIECE_INVALID : PIECE_EMPTY,
                                 6'($urandom));
               2, 3, 4: send_word(any_word(ACTION_NOP));
               default: send_regen();
            endcase
         end else begin
            send_toggle(1'($urandom), 3'($urandom_range(1, 6)), 6'($urandom));
         end
      end
      send_finish(1'($urandom), 4'($urandom),
                  ($urandom_range(0, 3) == 0) ? 4'b1111 : 4'($urandom));
   endtask

   task automatic test_directed();
      check_seed_readback();
      send_regen();
      send_toggle(1'b0, 3'd1, 6'd0);
      send_toggle(1'b1, 3'd6, 6'd63);
      send_toggle(1'b0, PIECE_EMPTY, 6'd5);
      send_toggle(1'b1, PIECE_INVALID, 6'd9);
      send_word(any_word(ACTION_NOP));
      send_finish(1'b0, 4'd0, 4'b1111);
      send_finish(1'b1, 4'd15, 4'd7);
      send_toggle(1'b1, 3'd3, 6'd42);
      send_toggle(1'b1, 3'd3, 6'd42);
      send_finish(1'b0, 4'd5, 4'd0);
      send_toggle(1'b0, 3'd2, 6'd17);
      send_finish(1'b1, 4'd10, 4'b1000);
      // accumulator survives a regenerate
      send_toggle(1'b0, 3'd4, 6'd30);
      send_toggle(1'b1, 3'd5, 6'd7);
      send_regen();
      send_finish(1'b0, 4'd3, 4'd4);
      send_toggle(1'b0, 3'd6, 6'd56);
      send_finish(1'b1, 4'd1, 4'b1110);
      wait_idle();
   endtask

   task automatic test_seed_extremes();
      logic [63:0] seeds [4];
      int          k;
      seeds[0] = '0;
      seeds[1] = '1;
      seeds[2] = {$urandom, $urandom};
      seeds[3] = SEED_AT_RESET;
      for (k = 0; k < 4; k++) begin
         write_seed(seeds[k]);
         check_seed_readback();
         // old keys stay in use until the next regenerate
         play_game(8, 0);
         send_regen();
         play_game(12, 10);
         play_game(3, 0);
         wait_idle();
      end
   endtask

   task automatic test_random_games();
      int phase;
      int stop_at;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet = (phase == 0);
         write_seed({$urandom, $urandom});
         check_seed_readback();
         send_regen();
         stop_at = words_queued + RANDOM_WORDS / RANDOM_PHASES;
         while (words_queued < stop_at)
            play_game($urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                : $urandom_range(4, 40), 6);
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_seed_extremes();
      test_random_games();
      wait_idle();
      $display("sent %0d words under %0d seeds with %0d key regenerations",
               words_sent, seeds_used, regen_count);
      $display("checked %0d position hashes against the prediction", hashes_checked);
      if (error_count == 0 && hash_q.size() == 0) begin
         $display("zobrist_position_hash_core verification clean");
      end else begin
         $display("zobrist_position_hash_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
